// ===== sv/hsv_percent_to_rgb_defines.svh =====
// Assertion macros used by the converter's RTL file.
// Each macro checks on the rising edge of clk and stays quiet while reset is asserted.
`ifndef HSV_PERCENT_TO_RGB_DEFINES_SVH
`define HSV_PERCENT_TO_RGB_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSVP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSVP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hsvp_pkg.sv =====
package hsvp_pkg;

    localparam int HUE_W  = 9;
    localparam int PCT_W  = 7;
    localparam int CHAN_W = 8;
    localparam int NUM_CH = 3;

    // Width of (255 - c) * (100 - s) and of c * t; neither exceeds 25500.
    localparam int PROD_W  = 15;
    // floor(x / 100) equals (x * 5243) >> 19 for every x below 25600.
    localparam int RECIP_W = 13;
    localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
    localparam int                 RECIP_SHIFT = 19;

    localparam logic [HUE_W-1:0]  HUE_MAX  = 9'd359;
    localparam logic [PCT_W-1:0]  PCT_MAX  = 7'd100;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
    localparam logic [CHAN_W-1:0] CHAN_MIN = 8'd0;

    // Upper bounds of the first five hue sectors.
    localparam logic [HUE_W-1:0] SECT_1 = 9'd60;
    localparam logic [HUE_W-1:0] SECT_2 = 9'd120;
    localparam logic [HUE_W-1:0] SECT_3 = 9'd180;
    localparam logic [HUE_W-1:0] SECT_4 = 9'd240;
    localparam logic [HUE_W-1:0] SECT_5 = 9'd300;

    // Ramp slope of 17/4 per degree; a full sector spans 1020 / 4.
    localparam logic [4:0] RAMP_SLOPE = 5'd17;
    localparam logic [9:0] RAMP_FULL  = 10'd1020;

    // Largest output: 255 * 65 / 100.
    localparam logic [CHAN_W-1:0] OUT_MAX = 8'd165;

    typedef logic [HUE_W-1:0]  hue_t;
    typedef logic [PCT_W-1:0]  pct_t;
    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [PROD_W-1:0] prod_t;

    // floor(v^(1/1.1)) for v = 0..100.
    localparam pct_t BRIGHT_MAP [0:100] = '{
         7'd0,  7'd1,  7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd5,  7'd6,  7'd7,
         7'd8,  7'd8,  7'd9, 7'd10, 7'd11, 7'd11, 7'd12, 7'd13, 7'd13, 7'd14,
        7'd15, 7'd15, 7'd16, 7'd17, 7'd17, 7'd18, 7'd19, 7'd20, 7'd20, 7'd21,
        7'd22, 7'd22, 7'd23, 7'd24, 7'd24, 7'd25, 7'd25, 7'd26, 7'd27, 7'd27,
        7'd28, 7'd29, 7'd29, 7'd30, 7'd31, 7'd31, 7'd32, 7'd33, 7'd33, 7'd34,
        7'd35, 7'd35, 7'd36, 7'd36, 7'd37, 7'd38, 7'd38, 7'd39, 7'd40, 7'd40,
        7'd41, 7'd41, 7'd42, 7'd43, 7'd43, 7'd44, 7'd45, 7'd45, 7'd46, 7'd46,
        7'd47, 7'd48, 7'd48, 7'd49, 7'd50, 7'd50, 7'd51, 7'd51, 7'd52, 7'd53,
        7'd53, 7'd54, 7'd54, 7'd55, 7'd56, 7'd56, 7'd57, 7'd57, 7'd58, 7'd59,
        7'd59, 7'd60, 7'd60, 7'd61, 7'd62, 7'd62, 7'd63, 7'd63, 7'd64, 7'd65,
        7'd65
    };

    // Rising ramp, floor(17 * d / 4), for an offset d of 0 to 60 degrees.
    function automatic chan_t ramp_rise(input logic [5:0] d);
        logic [9:0] prod;
        prod = 10'(RAMP_SLOPE) * 10'(d);
        return prod[9:2];
    endfunction

    // Falling ramp, floor((1020 - 17 * d) / 4).
    function automatic chan_t ramp_fall(input logic [5:0] d);
        logic [9:0] prod;
        prod = RAMP_FULL - 10'(RAMP_SLOPE) * 10'(d);
        return prod[9:2];
    endfunction

    // Division by 100 through a reciprocal; the quotient fits in 8 bits for x up to 25500.
    function automatic chan_t div100(input prod_t x);
        logic [PROD_W+RECIP_W-1:0] prod;
        prod = (PROD_W + RECIP_W)'(x) * (PROD_W + RECIP_W)'(RECIP_100);
        return prod[RECIP_SHIFT +: CHAN_W];
    endfunction

endpackage

// ===== sv/hsvp_hsv_if.sv =====
interface hsvp_hsv_if import hsvp_pkg::*; ();
    logic valid;
    logic ready;
    hue_t hue;
    pct_t saturation;
    pct_t brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// ===== sv/hsvp_rgb_if.sv =====
interface hsvp_rgb_if import hsvp_pkg::*; ();
    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== sv/hsv_percent_to_rgb.sv =====
// An accepted hsv request passes through stages 1 to 5 and leaves as the rgb request it produces.
// Throughput: one request per cycle unless a full pipeline waits on rgb; five requests can be in flight at once.
// The output register is the last of the five stages, so intake goes on while a
// result waits, and stops only when all five stages hold data and rgb is stalled.
// Reset (rst_n low, asynchronous) empties every stage; data registers keep no reset.

`include "hsv_percent_to_rgb_defines.svh"

module hsv_percent_to_rgb import hsvp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    hsvp_hsv_if.sink   hsv,
    hsvp_rgb_if.source rgb
);

    // The pipeline has five stages:
    //   1. Clamp the inputs, pick the hue sector and build the pure colour,
    //      form 100 - s and look up the brightness factor t.
    //   2. Multiply the headroom 255 - c by 100 - s for each channel.
    //   3. Divide that product by 100 and add it to c (lift toward white).
    //   4. Multiply the lifted channel by t.
    //   5. Divide by 100; this stage is the output register.
    // Each stage takes new data when it is empty or when the stage after it
    // moves on in the same cycle, so bubbles close up and a stall loses nothing.

    // Stage valid bits and their load enables.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !v5_reg || rgb.ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign hsv.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= hsv.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp, sector selection and brightness lookup.
    // ------------------------------------------------------------------
    hue_t       hue_c;
    pct_t       sat_c;
    pct_t       bri_c;
    logic [5:0] d;
    chan_t      s1_c_next [NUM_CH];
    pct_t       s1_inv_next;
    pct_t       s1_t_next;

    chan_t      s1_c_reg [NUM_CH];
    pct_t       s1_inv_reg;
    pct_t       s1_t_reg;

    always_comb
    begin
        hue_c = (hsv.hue > HUE_MAX) ? HUE_MAX : hsv.hue;
        sat_c = (hsv.saturation > PCT_MAX) ? PCT_MAX : hsv.saturation;
        bri_c = (hsv.brightness > PCT_MAX) ? PCT_MAX : hsv.brightness;

        // Channel order in the arrays is red, green, blue.
        if (hue_c <= SECT_1)
        begin
            d = hue_c[5:0];
            s1_c_next[0] = CHAN_MAX;
            s1_c_next[1] = ramp_rise(d);
            s1_c_next[2] = CHAN_MIN;
        end
        else if (hue_c <= SECT_2)
        begin
            d = 6'(hue_c - SECT_1);
            s1_c_next[0] = ramp_fall(d);
            s1_c_next[1] = CHAN_MAX;
            s1_c_next[2] = CHAN_MIN;
        end
        else if (hue_c <= SECT_3)
        begin
            d = 6'(hue_c - SECT_2);
            s1_c_next[0] = CHAN_MIN;
            s1_c_next[1] = CHAN_MAX;
            s1_c_next[2] = ramp_rise(d);
        end
        else if (hue_c <= SECT_4)
        begin
            d = 6'(hue_c - SECT_3);
            s1_c_next[0] = CHAN_MIN;
            s1_c_next[1] = ramp_fall(d);
            s1_c_next[2] = CHAN_MAX;
        end
        else if (hue_c <= SECT_5)
        begin
            d = 6'(hue_c - SECT_4);
            s1_c_next[0] = ramp_rise(d);
            s1_c_next[1] = CHAN_MIN;
            s1_c_next[2] = CHAN_MAX;
        end
        else
        begin
            d = 6'(hue_c - SECT_5);
            s1_c_next[0] = CHAN_MAX;
            s1_c_next[1] = CHAN_MIN;
            s1_c_next[2] = ramp_fall(d);
        end

        s1_inv_next = PCT_MAX - sat_c;
        s1_t_next   = BRIGHT_MAP[bri_c];
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && hsv.valid)
        begin
            s1_c_reg   <= s1_c_next;
            s1_inv_reg <= s1_inv_next;
            s1_t_reg   <= s1_t_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: headroom times (100 - s).
    // ------------------------------------------------------------------
    prod_t s2_p_next [NUM_CH];
    prod_t s2_p_reg  [NUM_CH];
    chan_t s2_c_reg  [NUM_CH];
    pct_t  s2_inv_reg;
    pct_t  s2_t_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            s2_p_next[i] = PROD_W'(CHAN_MAX - s1_c_reg[i]) * PROD_W'(s1_inv_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            s2_p_reg   <= s2_p_next;
            s2_c_reg   <= s1_c_reg;
            s2_inv_reg <= s1_inv_reg;
            s2_t_reg   <= s1_t_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: lift toward white. The sum never exceeds 255.
    // ------------------------------------------------------------------
    chan_t s3_c_next [NUM_CH];
    chan_t s3_c_reg  [NUM_CH];
    pct_t  s3_t_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            s3_c_next[i] = s2_c_reg[i] + div100(s2_p_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            s3_c_reg <= s3_c_next;
            s3_t_reg <= s2_t_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scale by the brightness factor.
    // ------------------------------------------------------------------
    prod_t s4_m_next [NUM_CH];
    prod_t s4_m_reg  [NUM_CH];

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            s4_m_next[i] = PROD_W'(s3_c_reg[i]) * PROD_W'(s3_t_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            s4_m_reg <= s4_m_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: divide by 100 into the output register.
    // ------------------------------------------------------------------
    chan_t s5_c_next [NUM_CH];
    chan_t s5_c_reg  [NUM_CH];

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            s5_c_next[i] = div100(s4_m_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
        begin
            s5_c_reg <= s5_c_next;
        end
    end

    assign rgb.valid = v5_reg;
    assign rgb.red   = s5_c_reg[0];
    assign rgb.green = s5_c_reg[1];
    assign rgb.blue  = s5_c_reg[2];

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Intake may only stop when every stage is full and the output is held.
    `HSVP_ASSERT_SAME(a_no_idle_stall, !hsv.ready, v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && !rgb.ready, "input stalled while the pipeline has room")

    // A request with zero brightness carries a zero scale factor into stage 1.
    `HSVP_ASSERT_NEXT(a_dark_factor, hsv.valid && hsv.ready && hsv.brightness == '0, s1_t_reg == '0, "zero brightness gave a nonzero scale factor")

    // At full saturation the lift stage must pass the pure colour unchanged.
    `HSVP_ASSERT_NEXT(a_full_sat_lift, v2_reg && rdy3 && s2_inv_reg == '0, s3_c_reg[0] == $past(s2_c_reg[0]) && s3_c_reg[1] == $past(s2_c_reg[1]) && s3_c_reg[2] == $past(s2_c_reg[2]), "lift changed a fully saturated colour")

    // The brightness table tops out at 65, which bounds every channel.
    `HSVP_ASSERT_SAME(a_out_bound, rgb.valid, rgb.red <= OUT_MAX && rgb.green <= OUT_MAX && rgb.blue <= OUT_MAX, "output channel above its largest reachable value")

endmodule
